### rtl/core/tssg_pkg.sv
// Package for the touch strip scroll gesture engine.
// Holds the codes, the register reset values and the widths of the shared divider.
// It depends on nothing else.
package tssg_pkg;

    localparam int SENSORS_DEF     = 6;
    localparam int MAX_DETENTS_DEF = 16;

    localparam int DIV_W = 42;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [15:0] TAP_LIMIT_RST = 16'd200;
    localparam logic [6:0]  DECAY_RST     = 7'd95;
    localparam logic [9:0]  TICK_RST      = 10'd20;
    localparam logic        MOM_EN_RST    = 1'b1;

    localparam logic [1:0] OP_PRESS   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] CFG_TAP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DECAY     = 2'd1;
    localparam logic [1:0] CFG_TICK      = 2'd2;
    localparam logic [1:0] CFG_MOM_EN    = 2'd3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_TOUCH = 2'd1,
        MODE_COAST = 2'd2
    } mode_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL    = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_FIN    = 6'b001000,
        ST_COMMIT = 6'b010000,
        ST_EMIT   = 6'b100000
    } state_t;

    typedef enum logic [2:0] {
        STEP_CENT = 3'd0,
        STEP_RAW  = 3'd1,
        STEP_V1   = 3'd2,
        STEP_V2   = 3'd3,
        STEP_DEC  = 3'd4,
        STEP_DLT  = 3'd5
    } step_t;

endpackage

### rtl/core/touch_strip_scroll_gesture.sv
// Top level of the touch strip scroll gesture engine.
// Uses tssg_pkg; one shared multiply and restoring divide unit under a sequencer.

// An input word that needs no arithmetic (idle press, tap release, ignored pad,
// tick outside momentum) is handled in the idle state. A touch update runs up to
// four multiply-then-divide passes (one when no time has passed since the last
// update) and a momentum tick up to two (one when the speed decays below the stop
// threshold), each pass going through the shared unit as a multiply step, 42
// one-bit divide steps and a finish step. The block accepts no input word
// while it computes or while detent words wait to be taken.
module touch_strip_scroll_gesture
    #(
        parameter int SENSORS     = tssg_pkg::SENSORS_DEF,
        parameter int MAX_DETENTS = tssg_pkg::MAX_DETENTS_DEF
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        cfg_we,
        input  logic [1:0]  cfg_index,
        input  logic [15:0] cfg_data,
        input  logic        in_valid,
        output logic        in_ready,
        input  logic [1:0]  op,
        input  logic [2:0]  pad,
        input  logic [31:0] time_ms,
        output logic        out_valid,
        input  logic        out_ready,
        output logic        direction,
        output logic        last
    );
    import tssg_pkg::*;

    localparam int CNT_W = $clog2(MAX_DETENTS + 1);
    localparam int SUM_W = $clog2(SENSORS * SENSORS * 128 + 1);
    localparam int NUM_W = $clog2(SENSORS + 1);

    logic [15:0] tap_limit_reg;
    logic [6:0]  decay_reg;
    logic [9:0]  tick_reg;
    logic        mom_en_reg;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    mode_t  mode_reg, mode_next;
    logic [SENSORS-1:0] mask_reg, mask_next;
    logic [11:0] pos_reg, pos_next;
    logic signed [31:0] vel_reg, vel_next;
    logic [31:0] ltime_reg, ltime_next;
    logic signed [31:0] coast_reg, coast_next;
    logic signed [15:0] accum_reg, accum_next;
    logic [31:0] tstart_reg, tstart_next;
    logic [2:0]  spad_reg, spad_next;
    logic        moved_reg, moved_next;

    logic        press_reg, press_next;
    logic        trk_reg, trk_next;
    logic [31:0] now_reg, now_next;
    logic [11:0] np_reg, np_next;
    logic signed [31:0] raw_reg, raw_next;
    logic signed [31:0] t1_reg, t1_next;
    logic signed [16:0] sdelta_reg, sdelta_next;

    logic signed [31:0] opa_reg, opa_next;
    logic [9:0]  opb_reg, opb_next;
    logic [31:0] opd_reg, opd_next;
    logic        neg_reg, neg_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    logic [CNT_W-1:0] left_reg, left_next;
    logic        dir_reg, dir_next;

    logic [SENSORS-1:0] pad_bit, mask_new;
    logic [SUM_W-1:0] csum;
    logic [NUM_W-1:0] ccnt;
    logic        pad_ok;
    logic [31:0] a_mag;
    logic [32:0] trial;
    logic signed [DIV_W:0] res;
    logic signed [12:0] delta13;
    logic [31:0] dt;
    logic signed [12:0] off;
    logic signed [17:0] ssum;
    logic [17:0] smag;
    logic [9:0]  sq;
    logic signed [31:0] vsat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign direction = dir_reg;
    assign last      = (left_reg == CNT_W'(1));

    assign pad_ok  = ({1'b0, pad} < 4'(SENSORS));
    assign pad_bit = SENSORS'(1) << pad;
    assign mask_new = (op == OP_PRESS) ? (mask_reg | pad_bit) : (mask_reg & ~pad_bit);

    // Centroid numerator and pad count over the new pad mask.
    always_comb
    begin
        csum = '0;
        ccnt = '0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (mask_new[i])
            begin
                csum = csum + SUM_W'(i * 256);
                ccnt = ccnt + NUM_W'(1);
            end
        end
    end

    assign a_mag = opa_reg[31] ? 32'(-opa_reg) : 32'(opa_reg);
    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign res   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    assign delta13 = $signed({1'b0, res[11:0]}) - $signed({1'b0, pos_reg});
    assign dt      = now_reg - ltime_reg;
    assign off     = $signed({1'b0, np_reg}) - $signed({2'b0, spad_reg, 8'b0});
    assign ssum    = 18'(accum_reg) + 18'(sdelta_reg);
    assign smag    = ssum[17] ? 18'(-ssum) : 18'(ssum);
    assign sq      = smag[17:8];

    always_comb
    begin
        if (res > $signed(43'sh0_7FFF_FFFF))
            vsat = 32'sh7FFF_FFFF;
        else if (res < -$signed(43'sh0_8000_0000))
            vsat = -32'sh7FFF_FFFF - 32'sd1;
        else
            vsat = res[31:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        mode_next   = mode_reg;
        mask_next   = mask_reg;
        pos_next    = pos_reg;
        vel_next    = vel_reg;
        ltime_next  = ltime_reg;
        coast_next  = coast_reg;
        accum_next  = accum_reg;
        tstart_next = tstart_reg;
        spad_next   = spad_reg;
        moved_next  = moved_reg;
        press_next  = press_reg;
        trk_next    = trk_reg;
        now_next    = now_reg;
        np_next     = np_reg;
        raw_next    = raw_reg;
        t1_next     = t1_reg;
        sdelta_next = sdelta_reg;
        opa_next    = opa_reg;
        opb_next    = opb_reg;
        opd_next    = opd_reg;
        neg_next    = neg_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        dcnt_next   = dcnt_reg;
        left_next   = left_reg;
        dir_next    = dir_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next   = time_ms;
                    press_next = (op == OP_PRESS);
                    trk_next   = 1'b1;
                    if (op == OP_PRESS && pad_ok)
                    begin
                        mask_next = mask_new;
                        if (mode_reg == MODE_IDLE)
                        begin
                            mode_next   = MODE_TOUCH;
                            tstart_next = time_ms;
                            spad_next   = pad;
                            moved_next  = 1'b0;
                            accum_next  = '0;
                            vel_next    = '0;
                            pos_next    = {1'b0, pad, 8'b0};
                            ltime_next  = time_ms;
                        end
                        else if (mode_reg == MODE_TOUCH)
                        begin
                            state_next = ST_MUL;
                            step_next  = STEP_CENT;
                            opa_next   = 32'(csum);
                            opb_next   = 10'd1;
                            opd_next   = 32'(ccnt);
                        end
                    end
                    else if (op == OP_RELEASE && pad_ok)
                    begin
                        mask_next = mask_new;
                        if (mode_reg == MODE_TOUCH)
                        begin
                            if (mask_new == '0)
                            begin
                                if ((time_ms - tstart_reg) < {16'b0, tap_limit_reg} &&
                                    !moved_reg)
                                begin
                                    mode_next = MODE_IDLE;
                                    if (spad_reg <= 3'd1)
                                    begin
                                        state_next = ST_EMIT;
                                        left_next  = CNT_W'(1);
                                        dir_next   = 1'b1;
                                    end
                                    else if ({1'b0, spad_reg} >= 4'(SENSORS - 2))
                                    begin
                                        state_next = ST_EMIT;
                                        left_next  = CNT_W'(1);
                                        dir_next   = 1'b0;
                                    end
                                end
                                else if (mom_en_reg &&
                                         (vel_reg > 32'sd256 || vel_reg < -32'sd256))
                                begin
                                    coast_next = vel_reg;
                                    mode_next  = MODE_COAST;
                                end
                                else
                                begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            else
                            begin
                                state_next = ST_MUL;
                                step_next  = STEP_CENT;
                                opa_next   = 32'(csum);
                                opb_next   = 10'd1;
                                opd_next   = 32'(ccnt);
                            end
                        end
                    end
                    else if (op == OP_TICK && mode_reg == MODE_COAST)
                    begin
                        state_next = ST_MUL;
                        step_next  = STEP_DEC;
                        trk_next   = 1'b0;
                        opa_next   = coast_reg;
                        opb_next   = {3'b0, decay_reg};
                        opd_next   = 32'd100;
                    end
                end
            end

            ST_MUL:
            begin
                // An empty mask divides zero by one, which gives a centroid of zero.
                if (opd_reg == '0)
                    opd_next = 32'd1;
                quo_next   = DIV_W'({10'b0, a_mag} * {32'b0, opb_reg});
                neg_next   = opa_reg[31];
                rem_next   = '0;
                dcnt_next  = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                if (trial >= {1'b0, opd_reg})
                begin
                    rem_next = 32'(trial - {1'b0, opd_reg});
                    quo_next = {quo_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[31:0];
                    quo_next = {quo_reg[DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_CNT_W'(DIV_W - 1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                state_next = ST_MUL;
                case (step_reg)
                    STEP_CENT:
                    begin
                        np_next     = res[11:0];
                        sdelta_next = 17'(delta13);
                        if (dt != '0)
                        begin
                            step_next = STEP_RAW;
                            opa_next  = 32'(delta13);
                            opb_next  = 10'd1000;
                            opd_next  = dt;
                        end
                        else
                        begin
                            state_next = ST_COMMIT;
                        end
                    end
                    STEP_RAW:
                    begin
                        raw_next  = res[31:0];
                        step_next = STEP_V1;
                        opa_next  = vel_reg;
                        opb_next  = 10'd7;
                        opd_next  = 32'd10;
                    end
                    STEP_V1:
                    begin
                        t1_next   = res[31:0];
                        step_next = STEP_V2;
                        opa_next  = raw_reg;
                        opb_next  = 10'd3;
                        opd_next  = 32'd10;
                    end
                    STEP_V2:
                    begin
                        vel_next   = t1_reg + res[31:0];
                        state_next = ST_COMMIT;
                    end
                    STEP_DEC:
                    begin
                        coast_next = vsat;
                        if (vsat > -32'sd256 && vsat < 32'sd256)
                        begin
                            mode_next  = MODE_IDLE;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            step_next = STEP_DLT;
                            opa_next  = vsat;
                            opb_next  = tick_reg;
                            opd_next  = 32'd1000;
                        end
                    end
                    STEP_DLT:
                    begin
                        if (res > 43'sd32767)
                            sdelta_next = 17'sd32767;
                        else if (res < -43'sd32768)
                            sdelta_next = -17'sd32768;
                        else
                            sdelta_next = res[16:0];
                        state_next = ST_COMMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_COMMIT:
            begin
                if (trk_reg)
                begin
                    pos_next   = np_reg;
                    ltime_next = now_reg;
                    if (press_reg && (off > 13'sd256 || off < -13'sd256))
                        moved_next = 1'b1;
                end
                // Whole detents leave the accumulator; the remainder keeps its sign.
                accum_next = ssum[17] ? -16'(smag[7:0]) : 16'(smag[7:0]);
                dir_next   = ssum[17];
                if (sq == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                    left_next  = (sq > 10'(MAX_DETENTS)) ? CNT_W'(MAX_DETENTS) : CNT_W'(sq);
                end
            end

            ST_EMIT:
            begin
                if (out_ready)
                begin
                    left_next = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_limit_reg <= TAP_LIMIT_RST;
            decay_reg     <= DECAY_RST;
            tick_reg      <= TICK_RST;
            mom_en_reg    <= MOM_EN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_LIMIT: tap_limit_reg <= cfg_data;
                CFG_DECAY:     decay_reg     <= cfg_data[6:0];
                CFG_TICK:      tick_reg      <= cfg_data[9:0];
                CFG_MOM_EN:    mom_en_reg    <= cfg_data[0];
                default:       mom_en_reg    <= mom_en_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            step_reg   <= STEP_CENT;
            mode_reg   <= MODE_IDLE;
            mask_reg   <= '0;
            pos_reg    <= '0;
            vel_reg    <= '0;
            ltime_reg  <= '0;
            coast_reg  <= '0;
            accum_reg  <= '0;
            tstart_reg <= '0;
            spad_reg   <= '0;
            moved_reg  <= 1'b0;
            left_reg   <= '0;
            dcnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            mode_reg   <= mode_next;
            mask_reg   <= mask_next;
            pos_reg    <= pos_next;
            vel_reg    <= vel_next;
            ltime_reg  <= ltime_next;
            coast_reg  <= coast_next;
            accum_reg  <= accum_next;
            tstart_reg <= tstart_next;
            spad_reg   <= spad_next;
            moved_reg  <= moved_next;
            left_reg   <= left_next;
            dcnt_reg   <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg  <= press_next;
        trk_reg    <= trk_next;
        now_reg    <= now_next;
        np_reg     <= np_next;
        raw_reg    <= raw_next;
        t1_reg     <= t1_next;
        sdelta_reg <= sdelta_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        opd_reg    <= opd_next;
        neg_reg    <= neg_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        dir_reg    <= dir_next;
    end

endmodule

### rtl/core/tssg_checker.sv
// Port-level checker for touch_strip_scroll_gesture, attached by bind.
// Depends only on the top level's ports.
module tssg_props
    (
        input logic clk,
        input logic rst_n,
        input logic in_ready,
        input logic out_valid,
        input logic out_ready,
        input logic direction,
        input logic last
    );

    // Detent words are delivered only while no new input word is taken.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !in_ready)
        else $error("input ready while a detent word is pending");

    // The final detent word of an input ends the burst.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last |=> !out_valid)
        else $error("detent word after the final one");

    // A stalled detent word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(direction) && $stable(last))
        else $error("stalled detent word changed");

endmodule

bind touch_strip_scroll_gesture tssg_props u_tssg_props
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ready(in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .direction(direction),
        .last(last)
    );
